FILE: hw/rtl/prqs_pkg.sv
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and constants of the priority run-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int PriorityLevelsDef = 140;
  localparam int MaxThreadsDef     = 64;
  localparam int ScanGroup         = 16;

  localparam logic [15:0] SLICE_RESET = 16'd4;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_DUP      = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_YIELD  = 2'd2,
    MODE_TICK   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TK_RD,
    S_ENQ_LV,
    S_ENQ_RD,
    S_ENQ_LINK,
    S_SCAN,
    S_DISP_RD,
    S_DISP_HT,
    S_DISP_NX,
    S_RM_LV,
    S_RM_HT,
    S_RM_WALK,
    S_RM_FIX,
    S_DONE
  } state_e;

  // One classified command between the front and the back.
  typedef struct packed {
    mode_e       mode;
    logic [5:0]  tid;
    logic        tid_ok;
    logic [7:0]  level;
  } cmd_t;

endpackage

FILE: hw/rtl/prqs_front.sv
// ----------------------------------------------------------------------------
// prqs_front
// Accepts input beats, range-checks the thread number and clamps the level.
// ----------------------------------------------------------------------------
module prqs_front #(
  parameter int PRIORITY_LEVELS = prqs_pkg::PriorityLevelsDef,
  parameter int MAX_THREADS     = prqs_pkg::MaxThreadsDef
) (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     mode_i,
  input  logic [5:0]     thread_id_i,
  input  logic [7:0]     priority_req_i,
  input  logic           fifo_full_i,
  output logic           push_o,
  output prqs_pkg::cmd_t cmd_o
);

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i & ~fifo_full_i;

  always_comb begin
    cmd_o.mode   = prqs_pkg::mode_e'(mode_i);
    cmd_o.tid    = thread_id_i;
    cmd_o.tid_ok = (32'(thread_id_i) < MAX_THREADS);
    if (32'(priority_req_i) > PRIORITY_LEVELS - 1) begin
      cmd_o.level = 8'(PRIORITY_LEVELS - 1);
    end else begin
      cmd_o.level = priority_req_i;
    end
  end

endmodule

FILE: hw/rtl/prqs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// prqs_cmd_fifo
// Two-entry command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module prqs_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  prqs_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output prqs_pkg::cmd_t cmd_o
);

  prqs_pkg::cmd_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: hw/rtl/prqs_back.sv
// ----------------------------------------------------------------------------
// prqs_back
// Sequencer that carries out commands on the level queues and holds results.
// ----------------------------------------------------------------------------
module prqs_back #(
  parameter int PRIORITY_LEVELS = prqs_pkg::PriorityLevelsDef,
  parameter int MAX_THREADS     = prqs_pkg::MaxThreadsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  prqs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic [15:0]    slice_len_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [5:0]     running_thread_o,
  output logic           running_valid_o,
  output logic           switched_o,
  output logic [1:0]     status_o,
  output logic [6:0]     queued_count_o
);

  localparam int TW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int LW  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int CW  = $clog2(MAX_THREADS + 1);
  localparam int G   = prqs_pkg::ScanGroup;
  localparam int GBW = $clog2(prqs_pkg::ScanGroup);
  localparam int NG  = (PRIORITY_LEVELS + G - 1) / G;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;

  prqs_pkg::state_e state_q, state_d;

  // Memories.
  logic [TW-1:0] head_mem [PRIORITY_LEVELS];
  logic [TW-1:0] tail_mem [PRIORITY_LEVELS];
  logic [TW-1:0] next_mem [MAX_THREADS];
  logic [LW-1:0] lvl_mem  [MAX_THREADS];
  logic [15:0]   slc_mem  [MAX_THREADS];
  logic [TW-1:0] head_rd, tail_rd, next_rd;
  logic [LW-1:0] lvl_rd;
  logic [15:0]   slc_rd;

  logic          head_re, tail_re, next_re, lvl_re, slc_re;
  logic          head_we, tail_we, next_we, lvl_we, slc_we;
  logic [LW-1:0] head_ra, tail_ra, head_wa, tail_wa;
  logic [TW-1:0] next_ra, lvl_ra, slc_ra, next_wa, lvl_wa, slc_wa;
  logic [TW-1:0] head_wd, tail_wd, next_wd;
  logic [LW-1:0] lvl_wd;
  logic [15:0]   slc_wd;

  // Control and bookkeeping state.
  logic [PRIORITY_LEVELS-1:0] map_q;
  logic [MAX_THREADS-1:0]     queued_q;
  logic [TW-1:0]              t_q, cur_q, prev_q, tail_q;
  logic [LW-1:0]              lv_q;
  logic                       cur_vld_q, yld_q, has_prev_q, first_q, sw_q;
  logic [1:0]                 st_q;
  logic [CW-1:0]              cnt_q;
  logic [GIW-1:0]             scan_q;
  logic                       out_vld_q;

  // Decoded command.
  logic [TW-1:0] cmd_tid;
  logic [LW-1:0] cmd_lv;
  logic          add_bad, rem_bad;

  // Scan of the nonempty map.
  logic [NG*G-1:0] map_pad;
  logic [G-1:0]    grp;
  logic [GBW-1:0]  fb;
  logic            grp_any, scan_last;
  logic [LW-1:0]   lv_found;

  logic [TW-1:0] cur_w;
  logic          out_load;

  assign cmd_tid = TW'(cmd_i.tid);
  assign cmd_lv  = LW'(cmd_i.level);
  assign add_bad = !cmd_i.tid_ok || queued_q[cmd_tid] || (cur_vld_q && cur_q == cmd_tid);
  assign rem_bad = !cmd_i.tid_ok || !queued_q[cmd_tid];

  assign map_pad   = (NG*G)'(map_q);
  assign grp       = map_pad[int'(scan_q)*G +: G];
  assign grp_any   = |grp;
  assign scan_last = (scan_q == GIW'(NG - 1));
  assign lv_found  = LW'(int'(scan_q) * G + int'(fb));

  always_comb begin
    fb = '0;
    for (int b = G - 1; b >= 0; b--) begin
      if (grp[b]) fb = GBW'(b);
    end
  end

  // The walk uses the head on its first step and the fetched link after.
  assign cur_w    = first_q ? head_rd : next_rd;
  assign out_load = !out_vld_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prqs_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.mode)
            prqs_pkg::MODE_ADD:    state_d = add_bad ? prqs_pkg::S_DONE : prqs_pkg::S_ENQ_RD;
            prqs_pkg::MODE_REMOVE: state_d = rem_bad ? prqs_pkg::S_DONE : prqs_pkg::S_RM_LV;
            prqs_pkg::MODE_YIELD:  state_d = cur_vld_q ? prqs_pkg::S_ENQ_LV : prqs_pkg::S_SCAN;
            prqs_pkg::MODE_TICK:   state_d = cur_vld_q ? prqs_pkg::S_TK_RD : prqs_pkg::S_DONE;
            default:               state_d = prqs_pkg::S_DONE;
          endcase
        end
      end
      prqs_pkg::S_TK_RD:    state_d = (slc_rd <= 16'd1) ? prqs_pkg::S_ENQ_LV : prqs_pkg::S_DONE;
      prqs_pkg::S_ENQ_LV:   state_d = prqs_pkg::S_ENQ_RD;
      prqs_pkg::S_ENQ_RD: begin
        if (map_q[lv_q]) state_d = prqs_pkg::S_ENQ_LINK;
        else             state_d = yld_q ? prqs_pkg::S_SCAN : prqs_pkg::S_DONE;
      end
      prqs_pkg::S_ENQ_LINK: state_d = yld_q ? prqs_pkg::S_SCAN : prqs_pkg::S_DONE;
      prqs_pkg::S_SCAN: begin
        if (grp_any)        state_d = prqs_pkg::S_DISP_RD;
        else if (scan_last) state_d = prqs_pkg::S_DONE;
      end
      prqs_pkg::S_DISP_RD:  state_d = prqs_pkg::S_DISP_HT;
      prqs_pkg::S_DISP_HT:  state_d = (tail_rd == head_rd) ? prqs_pkg::S_DONE
                                                           : prqs_pkg::S_DISP_NX;
      prqs_pkg::S_DISP_NX:  state_d = prqs_pkg::S_DONE;
      prqs_pkg::S_RM_LV:    state_d = prqs_pkg::S_RM_HT;
      prqs_pkg::S_RM_HT:    state_d = prqs_pkg::S_RM_WALK;
      prqs_pkg::S_RM_WALK: begin
        if (cur_w == t_q)        state_d = (tail_q == t_q) ? prqs_pkg::S_DONE
                                                           : prqs_pkg::S_RM_FIX;
        else if (cur_w == tail_q) state_d = prqs_pkg::S_DONE;
      end
      prqs_pkg::S_RM_FIX:   state_d = prqs_pkg::S_DONE;
      prqs_pkg::S_DONE:     if (out_load) state_d = prqs_pkg::S_IDLE;
      default:              state_d = prqs_pkg::S_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    cmd_pop_o = 1'b0;
    head_re = 1'b0; tail_re = 1'b0; next_re = 1'b0; lvl_re = 1'b0; slc_re = 1'b0;
    head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; lvl_we = 1'b0; slc_we = 1'b0;
    head_ra = lv_q; tail_ra = lv_q; head_wa = lv_q; tail_wa = lv_q;
    next_ra = t_q;  lvl_ra = cur_q; slc_ra = cur_q;
    next_wa = prev_q; lvl_wa = cmd_tid; slc_wa = cur_q;
    head_wd = t_q; tail_wd = t_q; next_wd = t_q;
    lvl_wd = cmd_lv; slc_wd = slice_len_i;
    unique case (state_q)
      prqs_pkg::S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          unique case (cmd_i.mode)
            prqs_pkg::MODE_ADD: begin
              lvl_we = !add_bad;
              slc_we = !add_bad;
              slc_wa = cmd_tid;
            end
            prqs_pkg::MODE_REMOVE: begin
              lvl_re = !rem_bad;
              lvl_ra = cmd_tid;
            end
            prqs_pkg::MODE_YIELD: lvl_re = cur_vld_q;
            prqs_pkg::MODE_TICK:  slc_re = cur_vld_q;
            default: ;
          endcase
        end
      end
      prqs_pkg::S_TK_RD: begin
        slc_we = 1'b1;
        if (slc_rd <= 16'd1) lvl_re = 1'b1;
        else                 slc_wd = slc_rd - 16'd1;
      end
      prqs_pkg::S_ENQ_RD: begin
        if (map_q[lv_q]) begin
          tail_re = 1'b1;
        end else begin
          head_we = 1'b1;
          tail_we = 1'b1;
        end
      end
      prqs_pkg::S_ENQ_LINK: begin
        next_we = 1'b1;
        next_wa = tail_rd;
        tail_we = 1'b1;
      end
      prqs_pkg::S_DISP_RD: begin
        head_re = 1'b1;
        tail_re = 1'b1;
      end
      prqs_pkg::S_DISP_HT: begin
        next_re = (tail_rd != head_rd);
        next_ra = head_rd;
      end
      prqs_pkg::S_DISP_NX: begin
        head_we = 1'b1;
        head_wd = next_rd;
      end
      prqs_pkg::S_RM_LV: begin
        head_re = 1'b1;
        tail_re = 1'b1;
        head_ra = lvl_rd;
        tail_ra = lvl_rd;
      end
      prqs_pkg::S_RM_WALK: begin
        if (cur_w == t_q) begin
          if (tail_q == t_q) begin
            tail_we = has_prev_q;
            tail_wd = prev_q;
          end else begin
            next_re = 1'b1;
          end
        end else if (cur_w != tail_q) begin
          next_re = 1'b1;
          next_ra = cur_w;
        end
      end
      prqs_pkg::S_RM_FIX: begin
        next_we = has_prev_q;
        next_wd = next_rd;
        head_we = !has_prev_q;
        head_wd = next_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_rd <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    if (lvl_re) lvl_rd <= lvl_mem[lvl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slc_we) slc_mem[slc_wa] <= slc_wd;
    if (slc_re) slc_rd <= slc_mem[slc_ra];
  end

  // Output beat registers.
  always_ff @(posedge clk_i) begin
    if (state_q == prqs_pkg::S_DONE && out_load) begin
      running_thread_o <= cur_vld_q ? 6'(cur_q) : 6'd0;
      running_valid_o  <= cur_vld_q;
      switched_o       <= sw_q;
      status_o         <= st_q;
      queued_count_o   <= 7'(cnt_q);
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= prqs_pkg::S_IDLE;
      map_q      <= '0;
      queued_q   <= '0;
      cur_q      <= '0;
      cur_vld_q  <= 1'b0;
      cnt_q      <= '0;
      t_q        <= '0;
      lv_q       <= '0;
      prev_q     <= '0;
      tail_q     <= '0;
      yld_q      <= 1'b0;
      has_prev_q <= 1'b0;
      first_q    <= 1'b0;
      sw_q       <= 1'b0;
      st_q       <= prqs_pkg::STATUS_DONE;
      scan_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != prqs_pkg::S_SCAN) scan_q <= '0;
      if (state_q == prqs_pkg::S_DONE && out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        prqs_pkg::S_IDLE: begin
          if (cmd_valid_i) begin
            sw_q  <= 1'b0;
            yld_q <= (cmd_i.mode == prqs_pkg::MODE_YIELD);
            lv_q  <= cmd_lv;
            if (cmd_i.mode == prqs_pkg::MODE_YIELD) t_q <= cur_q;
            else                                    t_q <= cmd_tid;
            if (cmd_i.mode == prqs_pkg::MODE_ADD && add_bad) begin
              st_q <= prqs_pkg::STATUS_DUP;
            end else if (cmd_i.mode == prqs_pkg::MODE_REMOVE && rem_bad) begin
              st_q <= prqs_pkg::STATUS_NOTFOUND;
            end else begin
              st_q <= prqs_pkg::STATUS_DONE;
            end
          end
        end
        prqs_pkg::S_TK_RD: begin
          t_q   <= cur_q;
          yld_q <= 1'b1;
        end
        prqs_pkg::S_ENQ_LV: lv_q <= lvl_rd;
        prqs_pkg::S_ENQ_RD: begin
          if (!map_q[lv_q]) begin
            map_q[lv_q]   <= 1'b1;
            queued_q[t_q] <= 1'b1;
            cnt_q         <= cnt_q + CW'(1);
          end
        end
        prqs_pkg::S_ENQ_LINK: begin
          queued_q[t_q] <= 1'b1;
          cnt_q         <= cnt_q + CW'(1);
        end
        prqs_pkg::S_SCAN: begin
          if (grp_any) begin
            lv_q <= lv_found;
          end else if (scan_last) begin
            cur_vld_q <= 1'b0;
            cur_q     <= '0;
          end else begin
            scan_q <= scan_q + GIW'(1);
          end
        end
        prqs_pkg::S_DISP_HT: begin
          t_q <= head_rd;
          if (tail_rd == head_rd) begin
            map_q[lv_q]       <= 1'b0;
            queued_q[head_rd] <= 1'b0;
            cnt_q             <= cnt_q - CW'(1);
            cur_q             <= head_rd;
            cur_vld_q         <= 1'b1;
            sw_q              <= 1'b1;
          end
        end
        prqs_pkg::S_DISP_NX: begin
          queued_q[t_q] <= 1'b0;
          cnt_q         <= cnt_q - CW'(1);
          cur_q         <= t_q;
          cur_vld_q     <= 1'b1;
          sw_q          <= 1'b1;
        end
        prqs_pkg::S_RM_LV: lv_q <= lvl_rd;
        prqs_pkg::S_RM_HT: begin
          tail_q     <= tail_rd;
          first_q    <= 1'b1;
          has_prev_q <= 1'b0;
        end
        prqs_pkg::S_RM_WALK: begin
          first_q <= 1'b0;
          if (cur_w == t_q) begin
            if (tail_q == t_q) begin
              if (!has_prev_q) map_q[lv_q] <= 1'b0;
              queued_q[t_q] <= 1'b0;
              cnt_q         <= cnt_q - CW'(1);
            end
          end else if (cur_w != tail_q) begin
            prev_q     <= cur_w;
            has_prev_q <= 1'b1;
          end
        end
        prqs_pkg::S_RM_FIX: begin
          queued_q[t_q] <= 1'b0;
          cnt_q         <= cnt_q - CW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/priority_run_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_run_queue_scheduler_unit
// Bitmap priority scheduler with one FIFO of threads per priority level.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  mode, thread_id, priority_req
// out       output     out_valid_o / out_stall_i running_thread, running_valid,
//                                               switched, status, queued_count
// cfg       input      cfg_we_i                 cfg_wdata_i (slice_length)
//
// One beat is carried out at a time by the back sequencer, from the state
// that takes it from the queue through its final state: a rejected beat or
// an idle tick goes straight there, an add enqueues at its level's tail, a
// tick that does not expire counts down the slice, and remove reads the
// thread's level, then head and tail, and walks the list to unlink it. A
// yield requeues a running thread, scans the level map at 16 levels a cycle
// (up to 9 groups at 140 levels) and dispatches the lowest nonempty level's
// head, or none when all queues are empty; an expiring tick yields too.
// The result beat is valid the cycle after the final state. Two commands
// can wait in the queue between front and back; a stalled result holds the
// back in its final state. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module priority_run_queue_scheduler_unit #(
  parameter int PRIORITY_LEVELS = prqs_pkg::PriorityLevelsDef,
  parameter int MAX_THREADS     = prqs_pkg::MaxThreadsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  thread_id_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  running_thread_o,
  output logic        running_valid_o,
  output logic        switched_o,
  output logic [1:0]  status_o,
  output logic [6:0]  queued_count_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic           fifo_full, push, fifo_valid, pop;
  prqs_pkg::cmd_t cmd_in, cmd_out;
  logic [15:0]    slice_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q <= prqs_pkg::SLICE_RESET;
    end else if (cfg_we_i) begin
      slice_len_q <= cfg_wdata_i;
    end
  end

  prqs_front #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .MAX_THREADS     (MAX_THREADS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .thread_id_i    (thread_id_i),
    .priority_req_i (priority_req_i),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .cmd_o          (cmd_in)
  );

  prqs_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .cmd_o   (cmd_out)
  );

  prqs_back #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .MAX_THREADS     (MAX_THREADS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (fifo_valid),
    .cmd_i            (cmd_out),
    .cmd_pop_o        (pop),
    .slice_len_i      (slice_len_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .running_thread_o (running_thread_o),
    .running_valid_o  (running_valid_o),
    .switched_o       (switched_o),
    .status_o         (status_o),
    .queued_count_o   (queued_count_o)
  );

endmodule
